FILE: src/dda_pkg.sv
`default_nettype none
package dda_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 16;

  localparam int ACC_W  = COORD_BITS + FRAC_BITS;
  localparam int STEP_W = FRAC_BITS + 2;
  localparam int CNT_W  = COORD_BITS + 1;
  localparam int QUO_W  = FRAC_BITS + 1;
  localparam int REM_W  = COORD_BITS + 1;

  localparam int DIV_ITERS = FRAC_BITS + 1;
  localparam int ITER_W    = $clog2(DIV_ITERS);
  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(DIV_ITERS - 1);

  localparam logic [FRAC_BITS-1:0] HALF_FRAC = FRAC_BITS'(1) << (FRAC_BITS - 1);

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_STEP  = 1'b1;

  typedef struct packed {
    logic start;
    logic step;
    logic div_iter;
    logic div_first;
    logic finish;
    logic emit_first;
  } dda_cmd_t;

  typedef struct packed {
    logic out_free;
    logic steps_zero;
  } dda_stat_t;

endpackage
`default_nettype wire

FILE: src/dda_ctrl.sv
`default_nettype none
module dda_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              req_type,
  input  wire dda_pkg::dda_stat_t stat,
  output logic                   in_stall,
  output dda_pkg::dda_cmd_t      cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]                  state;
  logic [1:0]                  state_next;
  logic [dda_pkg::ITER_W-1:0]  iter;
  logic [dda_pkg::ITER_W-1:0]  iter_next;
  logic                        accept;

  assign in_stall = (state != ST_IDLE) || !stat.out_free;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    iter_next  = iter;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (req_type == dda_pkg::REQ_START) begin
            cmd.start = 1'b1;
            if (!stat.steps_zero) begin
              state_next = ST_DIV;
              iter_next  = '0;
            end
          end else begin
            cmd.step = 1'b1;
          end
        end
      end
      ST_DIV: begin
        cmd.div_iter  = 1'b1;
        cmd.div_first = (iter == '0);
        if (iter == dda_pkg::ITER_LAST) begin
          state_next = ST_EMIT;
        end else begin
          iter_next = iter + 1'b1;
        end
      end
      ST_EMIT: begin
        cmd.finish = 1'b1;
        if (stat.out_free) begin
          cmd.emit_first = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      iter  <= '0;
    end else begin
      state <= state_next;
      iter  <= iter_next;
    end
  end

endmodule
`default_nettype wire

FILE: src/dda_datapath.sv
`default_nettype none
module dda_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire dda_pkg::dda_cmd_t             cmd,
  input  wire logic [dda_pkg::COORD_BITS-1:0] x_start,
  input  wire logic [dda_pkg::COORD_BITS-1:0] y_start,
  input  wire logic [dda_pkg::COORD_BITS-1:0] x_end,
  input  wire logic [dda_pkg::COORD_BITS-1:0] y_end,
  input  wire logic                          out_stall,
  output dda_pkg::dda_stat_t                 stat,
  output logic                               out_valid,
  output logic [dda_pkg::COORD_BITS-1:0]     pixel_x,
  output logic [dda_pkg::COORD_BITS-1:0]     pixel_y,
  output logic                               pixel_valid,
  output logic                               last_pixel
);

  logic [dda_pkg::ACC_W-1:0]      x_accum;
  logic [dda_pkg::ACC_W-1:0]      y_accum;
  logic [dda_pkg::STEP_W-1:0]     x_step;
  logic [dda_pkg::STEP_W-1:0]     y_step;
  logic [dda_pkg::CNT_W-1:0]      steps_left;
  logic                           line_active;
  logic [dda_pkg::REM_W-1:0]      x_rem;
  logic [dda_pkg::REM_W-1:0]      y_rem;
  logic [dda_pkg::QUO_W-1:0]      x_quo;
  logic [dda_pkg::QUO_W-1:0]      y_quo;
  logic                           x_neg;
  logic                           y_neg;

  logic                           x_lt;
  logic                           y_lt;
  logic [dda_pkg::COORD_BITS-1:0] adx;
  logic [dda_pkg::COORD_BITS-1:0] ady;
  logic [dda_pkg::COORD_BITS-1:0] steps;
  logic [dda_pkg::REM_W-1:0]      x_trial;
  logic [dda_pkg::REM_W-1:0]      y_trial;
  logic                           x_ge;
  logic                           y_ge;
  logic [dda_pkg::ACC_W-1:0]      x_sum;
  logic [dda_pkg::ACC_W-1:0]      y_sum;
  logic [dda_pkg::CNT_W-1:0]      cnt_dec;
  logic                           do_step;
  logic [dda_pkg::STEP_W-1:0]     x_mag;
  logic [dda_pkg::STEP_W-1:0]     y_mag;

  assign x_lt  = x_end < x_start;
  assign y_lt  = y_end < y_start;
  assign adx   = x_lt ? (x_start - x_end) : (x_end - x_start);
  assign ady   = y_lt ? (y_start - y_end) : (y_end - y_start);
  assign steps = (adx > ady) ? adx : ady;

  assign stat.steps_zero = (steps == '0);
  assign stat.out_free   = !out_valid || !out_stall;

  assign x_trial = cmd.div_first ? x_rem : {x_rem[dda_pkg::REM_W-2:0], 1'b0};
  assign y_trial = cmd.div_first ? y_rem : {y_rem[dda_pkg::REM_W-2:0], 1'b0};
  assign x_ge    = x_trial >= steps_left;
  assign y_ge    = y_trial >= steps_left;

  assign x_mag = {1'b0, x_quo};
  assign y_mag = {1'b0, y_quo};

  assign x_sum = x_accum + {{(dda_pkg::ACC_W - dda_pkg::STEP_W){x_step[dda_pkg::STEP_W-1]}},
                            x_step};
  assign y_sum = y_accum + {{(dda_pkg::ACC_W - dda_pkg::STEP_W){y_step[dda_pkg::STEP_W-1]}},
                            y_step};
  assign cnt_dec = steps_left - 1'b1;
  assign do_step = line_active && (steps_left != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
      steps_left  <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.start) begin
        line_active <= !stat.steps_zero;
        steps_left  <= {1'b0, steps};
      end else if (cmd.step) begin
        if (do_step) begin
          steps_left  <= cnt_dec;
          line_active <= (cnt_dec != '0);
        end else begin
          line_active <= 1'b0;
        end
      end
      if ((cmd.start && stat.steps_zero) || cmd.step || cmd.emit_first) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      x_accum <= {x_start, dda_pkg::HALF_FRAC};
      y_accum <= {y_start, dda_pkg::HALF_FRAC};
      x_rem   <= {1'b0, adx};
      y_rem   <= {1'b0, ady};
      x_quo   <= '0;
      y_quo   <= '0;
      x_neg   <= x_lt;
      y_neg   <= y_lt;
      if (stat.steps_zero) begin
        x_step <= '0;
        y_step <= '0;
      end
    end else if (cmd.step && do_step) begin
      x_accum <= x_sum;
      y_accum <= y_sum;
    end

    if (cmd.div_iter) begin
      x_rem <= x_ge ? (x_trial - steps_left) : x_trial;
      y_rem <= y_ge ? (y_trial - steps_left) : y_trial;
      x_quo <= {x_quo[dda_pkg::QUO_W-2:0], x_ge};
      y_quo <= {y_quo[dda_pkg::QUO_W-2:0], y_ge};
    end

    if (cmd.finish) begin
      x_step <= x_neg ? (dda_pkg::STEP_W'(0) - x_mag) : x_mag;
      y_step <= y_neg ? (dda_pkg::STEP_W'(0) - y_mag) : y_mag;
    end

    if (cmd.start && stat.steps_zero) begin
      pixel_x     <= x_start;
      pixel_y     <= y_start;
      pixel_valid <= 1'b1;
      last_pixel  <= 1'b1;
    end else if (cmd.emit_first) begin
      pixel_x     <= x_accum[dda_pkg::ACC_W-1:dda_pkg::FRAC_BITS];
      pixel_y     <= y_accum[dda_pkg::ACC_W-1:dda_pkg::FRAC_BITS];
      pixel_valid <= 1'b1;
      last_pixel  <= 1'b0;
    end else if (cmd.step) begin
      if (do_step) begin
        pixel_x     <= x_sum[dda_pkg::ACC_W-1:dda_pkg::FRAC_BITS];
        pixel_y     <= y_sum[dda_pkg::ACC_W-1:dda_pkg::FRAC_BITS];
        pixel_valid <= 1'b1;
        last_pixel  <= (cnt_dec == '0);
      end else begin
        pixel_x     <= '0;
        pixel_y     <= '0;
        pixel_valid <= 1'b0;
        last_pixel  <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: src/dda_line_rasterizer.sv
// Step transaction: result registered in the cycle after acceptance; one step per
//   cycle while the output is not stalled. Start transaction, distinct endpoints: the
//   restoring divider forms FRAC_BITS+1 (17) quotient bits (one per cycle for x and y),
//   an emit state waits for room, then the pixel is registered; input stalls meanwhile.
// Start transaction, equal endpoints: single pixel in the cycle after acceptance.
// Synchronous active-high rst: no line active, output empty, controller idle.
`default_nettype none
module dda_line_rasterizer (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          req_type,
  input  wire logic [dda_pkg::COORD_BITS-1:0] x_start,
  input  wire logic [dda_pkg::COORD_BITS-1:0] y_start,
  input  wire logic [dda_pkg::COORD_BITS-1:0] x_end,
  input  wire logic [dda_pkg::COORD_BITS-1:0] y_end,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [dda_pkg::COORD_BITS-1:0]     pixel_x,
  output logic [dda_pkg::COORD_BITS-1:0]     pixel_y,
  output logic                               pixel_valid,
  output logic                               last_pixel
);

  dda_pkg::dda_cmd_t  cmd;
  dda_pkg::dda_stat_t stat;

  dda_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .req_type (req_type),
    .stat     (stat),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  dda_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .x_start     (x_start),
    .y_start     (y_start),
    .x_end       (x_end),
    .y_end       (y_end),
    .out_stall   (out_stall),
    .stat        (stat),
    .out_valid   (out_valid),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_valid (pixel_valid),
    .last_pixel  (last_pixel)
  );

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |-> (!out_valid || !out_stall))
    else $error("transaction accepted while result register blocked");

  a_invalid_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pixel_valid) |-> !last_pixel)
    else $error("last_pixel flagged on invalid result");

  a_divide_stalls: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && (req_type == dda_pkg::REQ_START) && !stat.steps_zero)
      |=> (in_stall && !cmd.start && !cmd.step))
    else $error("input not held during increment divide");

  a_emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_first |-> stat.out_free)
    else $error("first pixel emitted into occupied result register");

endmodule
`default_nettype wire
